// ===== rtl/jesl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the EXIF segment locator.
// Parse phases, outcome codes, marker codes and the Exif signature table.
// No dependencies.
package jesl_pkg;

	localparam int MAX_PREFIX_BYTES_DEF = 1048576;
	localparam int FIELD_W              = 21;
	localparam int OUT_DATA_W           = 48;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_MARK_FF,
		PH_MARK_CODE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_A1_LEN_HI,
		PH_A1_LEN_LO,
		PH_SIG,
		PH_SKIP,
		PH_NONE,
		PH_EXIF,
		PH_TIFF
	} phase_t;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_EXIF = 2'd1,
		OUT_TIFF = 2'd2,
		OUT_LONG = 2'd3
	} outcome_t;

	localparam logic [7:0]  MARK_PREFIX = 8'hFF;
	localparam logic [7:0]  MARK_SOI    = 8'hD8;
	localparam logic [7:0]  MARK_TEM    = 8'h01;
	localparam logic [7:0]  MARK_RST0   = 8'hD0;
	localparam logic [7:0]  MARK_RST7   = 8'hD7;
	localparam logic [7:0]  MARK_SOS    = 8'hDA;
	localparam logic [7:0]  MARK_EOI    = 8'hD9;
	localparam logic [7:0]  MARK_APP1   = 8'hE1;
	localparam logic [15:0] HDR_JPEG    = 16'hFFD8;
	localparam logic [15:0] HDR_II      = 16'h4949;
	localparam logic [15:0] HDR_MM      = 16'h4D4D;
	localparam logic [31:0] TIFF_II     = 32'h49492A00;
	localparam logic [31:0] TIFF_MM     = 32'h4D4D002A;
	localparam logic [2:0]  SIG_LAST    = 3'd5;

	// "Exif\0\0", one byte per match index
	function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h45;
			3'd1: b = 8'h78;
			3'd2: b = 8'h69;
			3'd3: b = 8'h66;
			3'd4: b = 8'h00;
			3'd5: b = 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/jpeg_exif_segment_locator.sv =====
`timescale 1ns / 1ps
// Locates the EXIF TIFF block in a JPEG or TIFF file prefix streamed a byte at a time.
// Depends on jesl_pkg for phases, outcome codes and marker constants.
//
// One byte is taken per clock while no last byte waits on a pending result, with no
// gaps needed between prefixes. Each byte is held in an input register, then the marker
// walk and the result are worked out in a single step and the result lands in the
// output register. The input keeps flowing while a result waits; only a second
// last byte stalls until the pending result is taken. m_tuser carries the outcome
// (0 none, 1 EXIF in APP1, 2 whole TIFF file, 3 prefix longer than MAX_PREFIX_BYTES);
// m_tdata carries the block offset and the length of the block present in the prefix.
module jpeg_exif_segment_locator #(
	parameter int MAX_PREFIX_BYTES = jesl_pkg::MAX_PREFIX_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // [7:0] data_byte
	input  logic                                 s_tlast,   // last_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [jesl_pkg::OUT_DATA_W-1:0]      m_tdata,   // [20:0] block_start, [41:21] block_length
	output logic [1:0]                           m_tuser    // [1:0] outcome
);
	import jesl_pkg::*;

	localparam int PW = $clog2(MAX_PREFIX_BYTES + 2);
	localparam int WW = (PW > FIELD_W) ? PW : FIELD_W;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_PREFIX_BYTES);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	phase_t        phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [31:0]   hdr_q, hdr_d;
	logic [7:0]    lenhi_q, lenhi_d;
	logic [15:0]   rem_q, rem_d;
	logic [2:0]    idx_q, idx_d;
	logic [PW-1:0] fstart_q, fstart_d;
	logic [15:0]   claim_q, claim_d;

	// output register
	logic                 out_valid_q;
	outcome_t             outcome_q;
	logic [FIELD_W-1:0]   start_q;
	logic [FIELD_W-1:0]   length_q;

	logic        out_free, s1_fire, feed_en;
	logic [31:0] hdr_shift;
	logic [15:0] len16, rem_dec;
	logic [WW-1:0] count_w, fstart_w, claim_w, here_w, avail_w;
	outcome_t     res_outcome;
	logic [WW-1:0] res_start, res_length;

	assign out_free = !out_valid_q || m_tready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	// next state for the byte held in the input stage
	assign hdr_shift = {hdr_q[23:0], byte_s1};
	assign len16     = {lenhi_q, byte_s1};
	assign rem_dec   = rem_q - 16'd1;
	assign feed_en   = (pos_q <= MAX_POS);

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		lenhi_d  = lenhi_q;
		rem_d    = rem_q;
		idx_d    = idx_q;
		fstart_d = fstart_q;
		claim_d  = claim_q;
		pos_d    = feed_en ? pos_q + PW'(1) : pos_q;
		if (feed_en) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_d = hdr_shift;
					if (pos_q == PW'(1)) begin
						if (hdr_shift[15:0] == HDR_JPEG) begin
							phase_d = PH_MARK_FF;
						end else if (hdr_shift[15:0] != HDR_II && hdr_shift[15:0] != HDR_MM) begin
							phase_d = PH_NONE;
						end
					end else if (pos_q >= PW'(3)) begin
						phase_d = (hdr_shift == TIFF_II || hdr_shift == TIFF_MM) ? PH_TIFF : PH_NONE;
					end
				end
				PH_MARK_FF: begin
					phase_d = (byte_s1 == MARK_PREFIX) ? PH_MARK_CODE : PH_NONE;
				end
				PH_MARK_CODE: begin
					if (byte_s1 == MARK_SOI || byte_s1 == MARK_TEM
					    || (byte_s1 >= MARK_RST0 && byte_s1 <= MARK_RST7)) begin
						phase_d = PH_MARK_FF;
					end else if (byte_s1 == MARK_SOS || byte_s1 == MARK_EOI) begin
						phase_d = PH_NONE;
					end else if (byte_s1 == MARK_APP1) begin
						phase_d = PH_A1_LEN_HI;
					end else begin
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					lenhi_d = byte_s1;
					phase_d = PH_LEN_LO;
				end
				PH_A1_LEN_HI: begin
					lenhi_d = byte_s1;
					phase_d = PH_A1_LEN_LO;
				end
				PH_LEN_LO, PH_A1_LEN_LO: begin
					if (len16 < 16'd2) begin
						phase_d = PH_NONE;
					end else begin
						rem_d = len16 - 16'd2;
						// an APP1 with room for the signature and at least one more byte
						if (phase_q == PH_A1_LEN_LO && len16 > 16'd8) begin
							idx_d   = 3'd0;
							phase_d = PH_SIG;
						end else if (len16 == 16'd2) begin
							phase_d = PH_MARK_FF;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SIG: begin
					rem_d = rem_dec;
					if (byte_s1 == exif_sig_byte(idx_q)) begin
						idx_d = idx_q + 3'd1;
						if (idx_q == SIG_LAST) begin
							fstart_d = pos_q + PW'(1);
							claim_d  = rem_dec;
							phase_d  = PH_EXIF;
						end
					end else begin
						phase_d = (rem_dec == 16'd0) ? PH_MARK_FF : PH_SKIP;
					end
				end
				PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						phase_d = PH_MARK_FF;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result for a prefix that ends with this byte
	assign count_w  = WW'(pos_d);
	assign fstart_w = WW'(fstart_d);
	assign claim_w  = WW'(claim_d);
	assign here_w   = (count_w >= fstart_w) ? count_w - fstart_w : '0;
	assign avail_w  = (claim_w < here_w) ? claim_w : here_w;

	always_comb begin
		res_outcome = OUT_NONE;
		res_start   = '0;
		res_length  = '0;
		if (pos_q >= MAX_POS) begin
			res_outcome = OUT_LONG;
		end else if (phase_d == PH_TIFF) begin
			res_outcome = OUT_TIFF;
			res_length  = count_w;
		end else if (phase_d == PH_EXIF && avail_w != '0) begin
			res_outcome = OUT_EXIF;
			res_start   = fstart_w;
			res_length  = avail_w;
		end
	end

	// state register: advance per byte, clear after each prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			hdr_q    <= '0;
			lenhi_q  <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
			fstart_q <= '0;
			claim_q  <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				phase_q  <= PH_HEADER;
				pos_q    <= '0;
				hdr_q    <= '0;
				lenhi_q  <= '0;
				rem_q    <= '0;
				idx_q    <= '0;
				fstart_q <= '0;
				claim_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				hdr_q    <= hdr_d;
				lenhi_q  <= lenhi_d;
				rem_q    <= rem_d;
				idx_q    <= idx_d;
				fstart_q <= fstart_d;
				claim_q  <= claim_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			outcome_q <= res_outcome;
			start_q   <= res_start[FIELD_W-1:0];
			length_q  <= res_length[FIELD_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = outcome_q;
	assign m_tdata  = {{(OUT_DATA_W - 2 * FIELD_W){1'b0}}, length_q, start_q};

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> pos_q == '0 && phase_q == PH_HEADER)
		else $error("state not cleared after last byte");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s1_fire && last_s1))
		else $error("result without a last byte");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (outcome_q == OUT_NONE || outcome_q == OUT_LONG)
		|-> start_q == '0 && length_q == '0)
		else $error("non-zero fields without a block");

	a_tiff_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && outcome_q == OUT_TIFF |-> start_q == '0)
		else $error("TIFF file block not at offset zero");

	a_header_window: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> pos_q <= PW'(3))
		else $error("header phase beyond fourth byte");
`endif

endmodule
